// ===== rtl/akf_pkg.sv =====
package akf_pkg;

    // Sequencer states of the top level
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL_GO,
        ST_MUL_WAIT,
        ST_SUM,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_FINISH
    } akf_state_t;

    // Steps of one filter iteration, in issue order
    typedef enum logic [3:0] {
        STP_ANG,
        STP_P11DT,
        STP_T,
        STP_P10DT,
        STP_QA,
        STP_QB,
        STP_K0,
        STP_K1,
        STP_KA,
        STP_KB,
        STP_C0,
        STP_C1,
        STP_C2,
        STP_C3
    } akf_step_t;

    typedef enum logic [2:0] {
        MS_IDLE,
        MS_RUN,
        MS_RLO,
        MS_RHI,
        MS_SAT
    } akf_mul_state_t;

    typedef enum logic [1:0] {
        DS_IDLE,
        DS_RUN,
        DS_SAT
    } akf_div_state_t;

    typedef enum logic [1:0] {
        RNG_64,
        RNG_COV,
        RNG_32
    } akf_rng_t;

    // Control handed to the serial multiplier
    typedef struct packed {
        logic start;
        logic frac32;   // shift by 32 instead of 20
        logic sym_lim;  // negative limit is -max instead of min
    } akf_mul_ctl_t;

    localparam logic [1:0] CFG_START_ANGLE = 2'd0;
    localparam logic [1:0] CFG_Q_ANGLE     = 2'd1;
    localparam logic [1:0] CFG_Q_BIAS      = 2'd2;
    localparam logic [1:0] CFG_R_ACCEL     = 2'd3;

    localparam logic [31:0] Q_ANGLE_RST = 32'd4294967;
    localparam logic [31:0] Q_BIAS_RST  = 32'd12884902;
    localparam logic [31:0] R_ACCEL_RST = 32'd503316;

    localparam logic signed [63:0] S64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] S64_MIN = 64'sh8000_0000_0000_0000;

endpackage

// ===== rtl/akf_mul.sv =====
module akf_mul
    import akf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  akf_mul_ctl_t       ctl,
    input  logic signed [63:0] op_a,
    input  logic signed [63:0] op_b,
    output logic               done,
    output logic signed [63:0] result
);

    akf_mul_state_t state_reg, state_next;
    logic [63:0] am_reg, am_next;
    logic [63:0] bm_reg, bm_next;
    logic [63:0] hi_reg, hi_next;
    logic [63:0] lo_reg, lo_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        f32_reg, f32_next;
    logic        sym_reg, sym_next;
    logic        carry_reg, carry_next;
    logic        done_reg, done_next;
    logic signed [63:0] result_reg, result_next;

    always_comb
    begin
        logic [64:0] sum;
        logic [64:0] rnd;
        logic [63:0] half;
        logic [63:0] mag;
        logic        ovf;
        logic [63:0] lim;
        state_next  = state_reg;
        am_next     = am_reg;
        bm_next     = bm_reg;
        hi_next     = hi_reg;
        lo_next     = lo_reg;
        cnt_next    = cnt_reg;
        neg_next    = neg_reg;
        f32_next    = f32_reg;
        sym_next    = sym_reg;
        carry_next  = carry_reg;
        result_next = result_reg;
        done_next   = 1'b0;
        sum  = {1'b0, hi_reg} + (bm_reg[0] ? {1'b0, am_reg} : 65'd0);
        half = f32_reg ? 64'h0000_0000_8000_0000 : 64'h0000_0000_0008_0000;
        rnd  = {1'b0, lo_reg} + {1'b0, half};
        mag  = f32_reg ? {hi_reg[31:0], lo_reg[63:32]} : {hi_reg[19:0], lo_reg[63:20]};
        ovf  = f32_reg ? (|hi_reg[63:32]) : (|hi_reg[63:20]);
        lim  = sym_reg ? 64'h7FFF_FFFF_FFFF_FFFF : 64'h8000_0000_0000_0000;
        unique case (state_reg)
            MS_IDLE:
            begin
                if (ctl.start)
                begin
                    am_next    = op_a[63] ? (~op_a + 64'd1) : op_a;
                    bm_next    = op_b[63] ? (~op_b + 64'd1) : op_b;
                    hi_next    = '0;
                    lo_next    = '0;
                    cnt_next   = '0;
                    neg_next   = op_a[63] ^ op_b[63];
                    f32_next   = ctl.frac32;
                    sym_next   = ctl.sym_lim;
                    state_next = MS_RUN;
                end
            end
            MS_RUN:
            begin
                hi_next  = sum[64:1];
                lo_next  = {sum[0], lo_reg[63:1]};
                bm_next  = {1'b0, bm_reg[63:1]};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = MS_RLO;
            end
            MS_RLO:
            begin
                lo_next    = rnd[63:0];
                carry_next = rnd[64];
                state_next = MS_RHI;
            end
            MS_RHI:
            begin
                hi_next    = hi_reg + {63'd0, carry_reg};
                state_next = MS_SAT;
            end
            MS_SAT:
            begin
                if (ovf)
                    result_next = neg_reg ? (sym_reg ? -S64_MAX : S64_MIN) : S64_MAX;
                else if (neg_reg)
                    result_next = (mag >= lim) ? (sym_reg ? -S64_MAX : S64_MIN)
                                               : (~mag + 64'd1);
                else
                    result_next = (mag > 64'h7FFF_FFFF_FFFF_FFFF) ? S64_MAX : mag;
                done_next  = 1'b1;
                state_next = MS_IDLE;
            end
            default:
                state_next = MS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= MS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        am_reg     <= am_next;
        bm_reg     <= bm_next;
        hi_reg     <= hi_next;
        lo_reg     <= lo_next;
        cnt_reg    <= cnt_next;
        neg_reg    <= neg_next;
        f32_reg    <= f32_next;
        sym_reg    <= sym_next;
        carry_reg  <= carry_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== rtl/akf_div.sv =====
module akf_div
    import akf_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [63:0] num,
    input  logic signed [63:0] den,
    output logic               done,
    output logic signed [63:0] quot
);

    akf_div_state_t state_reg, state_next;
    logic [63:0] rem_reg, rem_next;
    logic [63:0] lo_reg, lo_next;
    logic [63:0] d_reg, d_next;
    logic [63:0] q_reg, q_next;
    logic [5:0]  cnt_reg, cnt_next;
    logic        neg_reg, neg_next;
    logic        ovf_reg, ovf_next;
    logic        done_reg, done_next;
    logic signed [63:0] quot_reg, quot_next;

    always_comb
    begin
        logic [63:0] nm;
        logic [63:0] dm;
        logic [64:0] rem_sh;
        logic        fits;
        state_next = state_reg;
        rem_next   = rem_reg;
        lo_next    = lo_reg;
        d_next     = d_reg;
        q_next     = q_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        ovf_next   = ovf_reg;
        quot_next  = quot_reg;
        done_next  = 1'b0;
        nm     = num[63] ? (~num + 64'd1) : num;
        dm     = den[63] ? (~den + 64'd1) : den;
        rem_sh = {rem_reg, lo_reg[63]};
        fits   = rem_sh >= {1'b0, d_reg};
        unique case (state_reg)
            DS_IDLE:
            begin
                if (start)
                begin
                    rem_next   = {32'd0, nm[63:32]};
                    lo_next    = {nm[31:0], 32'd0};
                    d_next     = dm;
                    q_next     = '0;
                    cnt_next   = '0;
                    neg_next   = num[63] ^ den[63];
                    ovf_next   = {32'd0, nm[63:32]} >= dm;
                    state_next = ({32'd0, nm[63:32]} >= dm) ? DS_SAT : DS_RUN;
                end
            end
            DS_RUN:
            begin
                // The partial remainder stays below the divisor, so 64 bits hold it
                rem_next = fits ? 64'(rem_sh - {1'b0, d_reg}) : rem_sh[63:0];
                lo_next  = {lo_reg[62:0], 1'b0};
                q_next   = {q_reg[62:0], fits};
                cnt_next = cnt_reg + 6'd1;
                if (cnt_reg == 6'd63)
                    state_next = DS_SAT;
            end
            DS_SAT:
            begin
                if (ovf_reg)
                    quot_next = neg_reg ? S64_MIN : S64_MAX;
                else if (neg_reg)
                    quot_next = q_reg[63] ? S64_MIN : (~q_reg + 64'd1);
                else
                    quot_next = q_reg[63] ? S64_MAX : q_reg;
                done_next  = 1'b1;
                state_next = DS_IDLE;
            end
            default:
                state_next = DS_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DS_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        lo_reg   <= lo_next;
        d_reg    <= d_next;
        q_reg    <= q_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        ovf_reg  <= ovf_next;
        quot_reg <= quot_next;
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

// ===== rtl/angle_kalman_filter.sv =====
// Each item runs twelve serial multiplies (one multiplier bit per cycle, 64 bits,
//   then rounding) and two serial divides (one quotient bit per cycle), one at
//   a time; both divides are skipped when the innovation variance S is zero.
// A new item is taken only after the previous result is in the output register.
// Reset (rst_n, async, active low) clears angle, bias and covariance to zero and
//   loads the noise registers with their defaults.
module angle_kalman_filter
    import akf_pkg::*;
#(
    parameter int COV_WIDTH = 48
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // time_step[19:0], gyro_rate[51:20], accel_angle[83:52], zero pad[87:84]
    input  logic [87:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // angle_out[31:0], bias_out[63:32]
    output logic [63:0] m_axis_tdata,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [31:0] cfg_wdata
);

    // Saturation limits, held one bit wider than the 64-bit working values
    localparam logic signed [64:0] L64_MAX  = 65'sh0_7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [64:0] L64_MIN  = -L64_MAX - 65'sd1;
    localparam logic signed [64:0] L32_MAX  = 65'sd2147483647;
    localparam logic signed [64:0] L32_MIN  = -L32_MAX - 65'sd1;
    localparam logic signed [64:0] LCOV_MAX = (65'sd1 <<< (COV_WIDTH - 1)) - 65'sd1;
    localparam logic signed [64:0] LCOV_MIN = -LCOV_MAX - 65'sd1;

    function automatic logic signed [63:0] sat_rng(input logic signed [64:0] v,
                                                   input akf_rng_t r);
        logic signed [64:0] lo;
        logic signed [64:0] hi;
        case (r)
            RNG_32:
            begin
                lo = L32_MIN;
                hi = L32_MAX;
            end
            RNG_COV:
            begin
                lo = LCOV_MIN;
                hi = LCOV_MAX;
            end
            default:
            begin
                lo = L64_MIN;
                hi = L64_MAX;
            end
        endcase
        if (v < lo)
            return lo[63:0];
        else if (v > hi)
            return hi[63:0];
        else
            return v[63:0];
    endfunction

    akf_state_t state_reg, state_next;
    akf_step_t  step_reg, step_next;

    logic [19:0]        dt_reg, dt_next;
    logic signed [31:0] rate_reg, rate_next;
    logic signed [31:0] accel_reg, accel_next;
    logic signed [31:0] angle_reg, angle_next;
    logic signed [31:0] bias_reg, bias_next;
    logic [31:0]        q_angle_reg, q_angle_next;
    logic [31:0]        q_bias_reg, q_bias_next;
    logic [31:0]        r_accel_reg, r_accel_next;
    logic signed [COV_WIDTH-1:0] cov_reg [4];
    logic signed [COV_WIDTH-1:0] cov_next [4];
    logic signed [COV_WIDTH-1:0] p00n_reg, p00n_next;
    logic signed [COV_WIDTH-1:0] p01n_reg, p01n_next;
    logic signed [COV_WIDTH-1:0] p10n_reg, p10n_next;
    logic signed [COV_WIDTH-1:0] p11n_reg, p11n_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [63:0] s_reg, s_next;
    logic signed [63:0] k0_reg, k0_next;
    logic signed [63:0] k1_reg, k1_next;
    logic signed [32:0] err_reg, err_next;
    logic               out_valid_reg, out_valid_next;
    logic [63:0]        out_data_reg, out_data_next;

    akf_mul_ctl_t       mul_ctl;
    logic signed [63:0] mul_a;
    logic signed [63:0] mul_b;
    logic               mul_done;
    logic signed [63:0] prod;
    logic               div_start;
    logic signed [63:0] div_num;
    logic               div_done;
    logic signed [63:0] quot;

    logic signed [63:0] dt64;
    logic signed [32:0] rate_diff;

    assign dt64      = {44'd0, dt_reg};
    assign rate_diff = 33'(rate_reg) - 33'(bias_reg);

    // Operand routing for the shared multiplier, one pair per step
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            STP_ANG:
            begin
                mul_a = dt64;
                mul_b = 64'(rate_diff);
            end
            STP_P11DT:
            begin
                mul_a = 64'(cov_reg[3]);
                mul_b = dt64;
            end
            STP_T:
            begin
                mul_a = t_reg;
                mul_b = dt64;
            end
            STP_P10DT:
            begin
                mul_a = 64'(cov_reg[2]);
                mul_b = dt64;
            end
            STP_QA:
            begin
                mul_a = {32'd0, q_angle_reg};
                mul_b = dt64;
            end
            STP_QB:
            begin
                mul_a = {32'd0, q_bias_reg};
                mul_b = dt64;
            end
            STP_KA:
            begin
                mul_a = k0_reg;
                mul_b = 64'(err_reg);
            end
            STP_KB:
            begin
                mul_a = k1_reg;
                mul_b = 64'(err_reg);
            end
            STP_C0:
            begin
                mul_a = k0_reg;
                mul_b = 64'(p00n_reg);
            end
            STP_C1:
            begin
                mul_a = k0_reg;
                mul_b = 64'(p01n_reg);
            end
            STP_C2:
            begin
                mul_a = k1_reg;
                mul_b = 64'(p00n_reg);
            end
            STP_C3:
            begin
                mul_a = k1_reg;
                mul_b = 64'(p01n_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // Gain products shift by 32, dt products by 20; covariance corrections
    // saturate symmetrically.
    assign mul_ctl.start   = (state_reg == ST_MUL_GO);
    assign mul_ctl.frac32  = (step_reg == STP_KA) || (step_reg == STP_KB) ||
                             (step_reg == STP_C0) || (step_reg == STP_C1) ||
                             (step_reg == STP_C2) || (step_reg == STP_C3);
    assign mul_ctl.sym_lim = (step_reg == STP_C0) || (step_reg == STP_C1) ||
                             (step_reg == STP_C2) || (step_reg == STP_C3);

    assign div_start = (state_reg == ST_DIV_GO) && (s_reg != 64'sd0);
    assign div_num   = (step_reg == STP_K0) ? 64'(p00n_reg) : 64'(p10n_reg);

    akf_mul u_mul (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (mul_ctl),
        .op_a   (mul_a),
        .op_b   (mul_b),
        .done   (mul_done),
        .result (prod)
    );

    akf_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (s_reg),
        .done  (div_done),
        .quot  (quot)
    );

    // Sequencer: one multiply or divide at a time, write back on its done pulse
    always_comb
    begin
        logic signed [64:0] p00x;
        logic signed [64:0] p01x;
        logic signed [64:0] p10x;
        logic signed [64:0] p11x;
        logic signed [64:0] px;
        state_next     = state_reg;
        step_next      = step_reg;
        dt_next        = dt_reg;
        rate_next      = rate_reg;
        accel_next     = accel_reg;
        angle_next     = angle_reg;
        bias_next      = bias_reg;
        q_angle_next   = q_angle_reg;
        q_bias_next    = q_bias_reg;
        r_accel_next   = r_accel_reg;
        cov_next       = cov_reg;
        p00n_next      = p00n_reg;
        p01n_next      = p01n_reg;
        p10n_next      = p10n_reg;
        p11n_next      = p11n_reg;
        t_next         = t_reg;
        s_next         = s_reg;
        k0_next        = k0_reg;
        k1_next        = k1_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;

        p00x = 65'(cov_reg[0]);
        p01x = 65'(cov_reg[1]);
        p10x = 65'(cov_reg[2]);
        p11x = 65'(cov_reg[3]);
        px   = 65'(prod);

        // Drop the held result once it is taken
        if (m_axis_tvalid && m_axis_tready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    dt_next    = s_axis_tdata[19:0];
                    rate_next  = s_axis_tdata[51:20];
                    accel_next = s_axis_tdata[83:52];
                    step_next  = STP_ANG;
                    state_next = ST_MUL_GO;
                end
            end
            ST_MUL_GO:
            begin
                // Fold the cross term into the P00 sum before the q_angle product lands
                if (step_reg == STP_QA)
                    s_next = sat_rng(65'(s_reg) - 65'(t_reg), RNG_64);
                state_next = ST_MUL_WAIT;
            end
            ST_MUL_WAIT:
            begin
                if (mul_done)
                begin
                    state_next = ST_MUL_GO;
                    case (step_reg)
                        STP_ANG:
                        begin
                            angle_next = 32'(sat_rng(65'(angle_reg) + px, RNG_32));
                            step_next  = STP_P11DT;
                        end
                        STP_P11DT:
                        begin
                            t_next    = sat_rng(p01x - px, RNG_64);
                            p01n_next = COV_WIDTH'(sat_rng(p01x - px, RNG_COV));
                            p10n_next = COV_WIDTH'(sat_rng(p10x - px, RNG_COV));
                            step_next = STP_T;
                        end
                        STP_T:
                        begin
                            t_next    = prod;
                            step_next = STP_P10DT;
                        end
                        STP_P10DT:
                        begin
                            s_next    = sat_rng(p00x - px, RNG_64);
                            step_next = STP_QA;
                        end
                        STP_QA:
                        begin
                            p00n_next = COV_WIDTH'(sat_rng(65'(s_reg) + px, RNG_COV));
                            step_next = STP_QB;
                        end
                        STP_QB:
                        begin
                            p11n_next  = COV_WIDTH'(sat_rng(p11x + px, RNG_COV));
                            state_next = ST_SUM;
                        end
                        STP_KA:
                        begin
                            angle_next = 32'(sat_rng(65'(angle_reg) + px, RNG_32));
                            step_next  = STP_KB;
                        end
                        STP_KB:
                        begin
                            bias_next = 32'(sat_rng(65'(bias_reg) + px, RNG_32));
                            step_next = STP_C0;
                        end
                        STP_C0:
                        begin
                            cov_next[0] = COV_WIDTH'(sat_rng(65'(p00n_reg) - px, RNG_COV));
                            step_next   = STP_C1;
                        end
                        STP_C1:
                        begin
                            cov_next[1] = COV_WIDTH'(sat_rng(65'(p01n_reg) - px, RNG_COV));
                            step_next   = STP_C2;
                        end
                        STP_C2:
                        begin
                            cov_next[2] = COV_WIDTH'(sat_rng(65'(p10n_reg) - px, RNG_COV));
                            step_next   = STP_C3;
                        end
                        STP_C3:
                        begin
                            cov_next[3] = COV_WIDTH'(sat_rng(65'(p11n_reg) - px, RNG_COV));
                            state_next  = ST_FINISH;
                        end
                        default:
                            state_next = ST_FINISH;
                    endcase
                end
            end
            ST_SUM:
            begin
                // Innovation variance S and innovation on the predicted angle
                s_next     = sat_rng(65'(p00n_reg) + {25'd0, r_accel_reg, 8'd0}, RNG_COV);
                err_next   = 33'(accel_reg) - 33'(angle_reg);
                step_next  = STP_K0;
                state_next = ST_DIV_GO;
            end
            ST_DIV_GO:
            begin
                if (s_reg == 64'sd0)
                begin
                    // Zero S: gains are zero, skip the divide
                    if (step_reg == STP_K0)
                    begin
                        k0_next   = '0;
                        step_next = STP_K1;
                    end
                    else
                    begin
                        k1_next    = '0;
                        step_next  = STP_KA;
                        state_next = ST_MUL_GO;
                    end
                end
                else
                    state_next = ST_DIV_WAIT;
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (step_reg == STP_K0)
                    begin
                        k0_next    = quot;
                        step_next  = STP_K1;
                        state_next = ST_DIV_GO;
                    end
                    else
                    begin
                        k1_next    = quot;
                        step_next  = STP_KA;
                        state_next = ST_MUL_GO;
                    end
                end
            end
            ST_FINISH:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || m_axis_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = {bias_reg, angle_reg};
                    state_next     = ST_IDLE;
                end
            end
            default:
                state_next = ST_IDLE;
        endcase

        if (cfg_wr_en)
        begin
            unique case (cfg_addr)
                CFG_START_ANGLE: angle_next   = cfg_wdata;
                CFG_Q_ANGLE:     q_angle_next = cfg_wdata;
                CFG_Q_BIAS:      q_bias_next  = cfg_wdata;
                CFG_R_ACCEL:     r_accel_next = cfg_wdata;
                default:         angle_next   = angle_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= STP_ANG;
            angle_reg     <= '0;
            bias_reg      <= '0;
            q_angle_reg   <= Q_ANGLE_RST;
            q_bias_reg    <= Q_BIAS_RST;
            r_accel_reg   <= R_ACCEL_RST;
            cov_reg       <= '{default: '0};
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            angle_reg     <= angle_next;
            bias_reg      <= bias_next;
            q_angle_reg   <= q_angle_next;
            q_bias_reg    <= q_bias_next;
            r_accel_reg   <= r_accel_next;
            cov_reg       <= cov_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dt_reg       <= dt_next;
        rate_reg     <= rate_next;
        accel_reg    <= accel_next;
        p00n_reg     <= p00n_next;
        p01n_reg     <= p01n_next;
        p10n_reg     <= p10n_next;
        p11n_reg     <= p11n_next;
        t_reg        <= t_next;
        s_reg        <= s_next;
        k0_reg       <= k0_next;
        k1_reg       <= k1_next;
        err_reg      <= err_next;
        out_data_reg <= out_data_next;
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    // A finished multiply only lands while the sequencer waits for it
    a_mul_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        mul_done |-> (state_reg == ST_MUL_WAIT))
        else $error("multiplier done outside wait state");

    a_div_done_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_DIV_WAIT))
        else $error("divider done outside wait state");

    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (s_axis_tvalid && s_axis_tready) |=> (state_reg == ST_MUL_GO) && (step_reg == STP_ANG))
        else $error("accepted item did not start the predict step");

    a_finish_out: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_FINISH) && (!out_valid_reg || m_axis_tready)) |=> m_axis_tvalid)
        else $error("finished item not presented");

endmodule

// ===== bench/tb_angle_kalman_filter.sv =====
module tb_angle_kalman_filter
    import akf_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    // Settle time after the last result: one full filter iteration plus margin
    localparam int SETTLE_CYCLES = 1100;
    // Generous ceiling on the whole run, in clock cycles
    localparam int CYCLE_LIMIT = 12000000;
    localparam int RX_HOLD_CYCLES = 4000;

    localparam logic signed [63:0] I32_MAX = 64'sd2147483647;
    localparam logic signed [63:0] I32_MIN = -64'sd2147483648;
    localparam logic signed [63:0] COV_MAX = (64'sd1 <<< 47) - 64'sd1;
    localparam logic signed [63:0] COV_MIN = -COV_MAX - 64'sd1;
    localparam logic signed [63:0] SYM_MIN = -S64_MAX;

    typedef struct packed {
        logic [31:0] accel_angle;
        logic [31:0] gyro_rate;
        logic [19:0] time_step;
    } imu_sample_t;

    typedef struct packed {
        logic [31:0] bias;
        logic [31:0] angle;
    } pitch_est_t;

    logic        clk;
    logic        rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    // time_step[19:0], gyro_rate[51:20], accel_angle[83:52], zero pad[87:84]
    logic [87:0] s_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    // angle_out[31:0], bias_out[63:32]
    logic [63:0] m_axis_tdata;
    logic        cfg_wr_en;
    logic [1:0]  cfg_addr;
    logic [31:0] cfg_wdata;

    imu_sample_t sample_q[$];
    pitch_est_t  estimate_q[$];

    // Predictor state: angle, bias, covariance and noise registers
    logic signed [63:0] pr_angle;
    logic signed [63:0] pr_bias;
    logic signed [63:0] pr_cov[4];
    logic [31:0]        pr_q_angle;
    logic [31:0]        pr_q_bias;
    logic [31:0]        pr_r_accel;

    int  tx_idle_pct;
    int  rx_idle_pct;
    int  rx_hold_cnt;
    bit  offered;
    int  error_cnt;
    int  cycle_cnt;

    angle_kalman_filter DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #1 clk = ~clk;

    // ---------------------------------------------------------------
    // Fixed-point predictor
    // ---------------------------------------------------------------

    function automatic logic [63:0] mag64(input logic signed [63:0] v);
        return v[63] ? (64'd0 - v) : v;
    endfunction

    // Put a sign on a magnitude and clamp to [lo, hi]
    function automatic logic signed [63:0] sign_sat(input bit neg, input logic [63:0] mag,
                                                    input logic signed [63:0] lo,
                                                    input logic signed [63:0] hi);
        logic [64:0] lim;
        lim = 65'd0 - {lo[63], lo};
        if (neg)
        begin
            if ({1'b0, mag} >= lim)
                return lo;
            return 64'd0 - mag;
        end
        if ({1'b0, mag} > {1'b0, hi})
            return hi;
        return mag;
    endfunction

    function automatic logic signed [63:0] add_clamp(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input logic signed [63:0] lo,
                                                     input logic signed [63:0] hi);
        logic signed [64:0] sum;
        sum = $signed({a[63], a}) + $signed({b[63], b});
        if (sum < $signed({lo[63], lo}))
            return lo;
        if (sum > $signed({hi[63], hi}))
            return hi;
        return sum[63:0];
    endfunction

    // Product shifted right with round half away from zero, then saturated
    function automatic logic signed [63:0] mul_round(input logic signed [63:0] a,
                                                     input logic signed [63:0] b,
                                                     input int sh,
                                                     input logic signed [63:0] lo,
                                                     input logic signed [63:0] hi);
        logic [127:0] p;
        bit neg;
        neg = a[63] != b[63];
        p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
        p = p + (128'd1 << (sh - 1));
        p = p >> sh;
        if (p[127:64] != 64'd0)
            return neg ? lo : hi;
        return sign_sat(neg, p[63:0], lo, hi);
    endfunction

    // Gain quotient (num << 32) / den, truncated, by sign and magnitude
    function automatic logic signed [63:0] gain_div(input logic signed [63:0] num,
                                                    input logic signed [63:0] den);
        logic [63:0] n;
        logic [63:0] d;
        logic [127:0] q;
        bit neg;
        neg = num[63] != den[63];
        n = mag64(num);
        d = mag64(den);
        if ((n >> 32) >= d)
            return neg ? S64_MIN : S64_MAX;
        q = {32'd0, n, 32'd0} / {64'd0, d};
        return sign_sat(neg, q[63:0], S64_MIN, S64_MAX);
    endfunction

    // Run predict and update on one sample and return the new estimate
    function automatic pitch_est_t filter_sample(input imu_sample_t smp);
        logic signed [63:0] dt;
        logic signed [63:0] rate;
        logic signed [63:0] accel;
        logic signed [63:0] t;
        logic signed [63:0] s;
        logic signed [63:0] p11dt;
        logic signed [63:0] n00;
        logic signed [63:0] n01;
        logic signed [63:0] n10;
        logic signed [63:0] n11;
        logic signed [63:0] err;
        logic signed [63:0] k0;
        logic signed [63:0] k1;
        pitch_est_t res;
        dt = {44'd0, smp.time_step};
        rate = {{32{smp.gyro_rate[31]}}, smp.gyro_rate};
        accel = {{32{smp.accel_angle[31]}}, smp.accel_angle};

        t = mul_round(dt, rate - pr_bias, 20, S64_MIN, S64_MAX);
        pr_angle = add_clamp(pr_angle, t, I32_MIN, I32_MAX);

        p11dt = mul_round(pr_cov[3], dt, 20, S64_MIN, S64_MAX);
        t = add_clamp(pr_cov[1], -p11dt, S64_MIN, S64_MAX);
        t = mul_round(t, dt, 20, S64_MIN, S64_MAX);
        s = add_clamp(pr_cov[0], -mul_round(pr_cov[2], dt, 20, S64_MIN, S64_MAX),
                      S64_MIN, S64_MAX);
        s = add_clamp(s, -t, S64_MIN, S64_MAX);
        s = add_clamp(s, mul_round({32'd0, pr_q_angle}, dt, 20, S64_MIN, S64_MAX),
                      S64_MIN, S64_MAX);
        n00 = add_clamp(s, 64'sd0, COV_MIN, COV_MAX);
        n01 = add_clamp(pr_cov[1], -p11dt, COV_MIN, COV_MAX);
        n10 = add_clamp(pr_cov[2], -p11dt, COV_MIN, COV_MAX);
        n11 = add_clamp(pr_cov[3], mul_round({32'd0, pr_q_bias}, dt, 20, S64_MIN, S64_MAX),
                        COV_MIN, COV_MAX);

        err = accel - pr_angle;
        s = add_clamp(n00, {24'd0, pr_r_accel, 8'd0}, COV_MIN, COV_MAX);
        k0 = 64'sd0;
        k1 = 64'sd0;
        // A zero innovation variance leaves both gains at zero
        if (s != 64'sd0)
        begin
            k0 = gain_div(n00, s);
            k1 = gain_div(n10, s);
        end
        pr_angle = add_clamp(pr_angle, mul_round(k0, err, 32, S64_MIN, S64_MAX),
                             I32_MIN, I32_MAX);
        pr_bias = add_clamp(pr_bias, mul_round(k1, err, 32, S64_MIN, S64_MAX),
                            I32_MIN, I32_MAX);
        pr_cov[0] = add_clamp(n00, -mul_round(k0, n00, 32, SYM_MIN, S64_MAX), COV_MIN, COV_MAX);
        pr_cov[1] = add_clamp(n01, -mul_round(k0, n01, 32, SYM_MIN, S64_MAX), COV_MIN, COV_MAX);
        pr_cov[2] = add_clamp(n10, -mul_round(k1, n00, 32, SYM_MIN, S64_MAX), COV_MIN, COV_MAX);
        pr_cov[3] = add_clamp(n11, -mul_round(k1, n01, 32, SYM_MIN, S64_MAX), COV_MIN, COV_MAX);

        res.angle = pr_angle[31:0];
        res.bias = pr_bias[31:0];
        return res;
    endfunction

    // ---------------------------------------------------------------
    // Driver: offer queued samples, predict on acceptance
    // ---------------------------------------------------------------

    always @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            estimate_q.push_back(filter_sample(sample_q.pop_front()));
            offered = 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && !offered)
        begin
            // Hold an offered item until it is taken; otherwise maybe idle
            if (sample_q.size() > 0 && $urandom_range(99) >= tx_idle_pct)
            begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {4'd0, sample_q[0]};
                offered = 1'b1;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // Receiver: random stalls plus a long hold-off when the stimulus sets one
    always @(negedge clk)
    begin
        if (rx_hold_cnt > 0)
        begin
            rx_hold_cnt <= rx_hold_cnt - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= rx_idle_pct);
    end

    // ---------------------------------------------------------------
    // Monitor and checks
    // ---------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycle_cnt);
        error_cnt++;
    endtask

    always @(posedge clk)
    begin
        pitch_est_t want;
        if (m_axis_tvalid && m_axis_tready)
        begin
            if (estimate_q.size() == 0)
                report_mismatch("unexpected item", m_axis_tdata[31:0], 32'd0);
            else
            begin
                want = estimate_q.pop_front();
                if (m_axis_tdata[31:0] !== want.angle)
                    report_mismatch("angle_out", m_axis_tdata[31:0], want.angle);
                if (m_axis_tdata[63:32] !== want.bias)
                    report_mismatch("bias_out", m_axis_tdata[63:32], want.bias);
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------

    // Write one register at a falling edge and mirror it into the predictor
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_START_ANGLE: pr_angle = {{32{val[31]}}, val};
            CFG_Q_ANGLE:     pr_q_angle = val;
            CFG_Q_BIAS:      pr_q_bias = val;
            CFG_R_ACCEL:     pr_r_accel = val;
            default:         ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // Wait until every expected result has come, then let the block settle
    task automatic drain();
        while (sample_q.size() > 0 || estimate_q.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] rand_q16();
        case ($urandom_range(3))
            0:       return $urandom();
            1:       return $urandom_range(32'h0200_0000) - 32'h0100_0000;
            default: return $urandom_range(32'h0014_0000) - 32'h000A_0000;
        endcase
    endfunction

    function automatic logic [19:0] rand_dt();
        case ($urandom_range(5))
            0:       return 20'($urandom());
            1:       return $urandom_range(1) ? 20'hFFFFF : 20'd0;
            2:       return 20'($urandom_range(20000));
            default: return 20'($urandom_range(900, 1200));
        endcase
    endfunction

    task automatic add_sample(input logic [19:0] dt, input logic [31:0] rate,
                              input logic [31:0] accel);
        imu_sample_t smp;
        smp.time_step = dt;
        smp.gyro_rate = rate;
        smp.accel_angle = accel;
        sample_q.push_back(smp);
    endtask

    task automatic add_random(input int n);
        repeat (n) add_sample(rand_dt(), rand_q16(), rand_q16());
    endtask

    task automatic random_regs();
        write_reg(CFG_START_ANGLE, rand_q16());
        write_reg(CFG_Q_ANGLE, $urandom_range(1) ? $urandom() : $urandom_range(50000000));
        write_reg(CFG_Q_BIAS, $urandom_range(1) ? $urandom() : $urandom_range(50000000));
        write_reg(CFG_R_ACCEL, $urandom_range(1) ? $urandom() : $urandom_range(5000000));
    endtask

    initial
    begin
        rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_addr = '0;
        cfg_wdata = '0;
        offered = 1'b0;
        error_cnt = 0;
        cycle_cnt = 0;
        rx_hold_cnt = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        pr_angle = 64'sd0;
        pr_bias = 64'sd0;
        for (int i = 0; i < 4; i++)
            pr_cov[i] = 64'sd0;
        pr_q_angle = Q_ANGLE_RST;
        pr_q_bias = Q_BIAS_RST;
        pr_r_accel = R_ACCEL_RST;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: zero innovation variance first (empty covariance, no noise)
        write_reg(CFG_R_ACCEL, 32'd0);
        add_sample(20'd0, 32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(20'd0, 32'h0001_0000, 32'h0000_0000);
        drain();
        write_reg(CFG_R_ACCEL, R_ACCEL_RST);
        // Field extremes, saturating angle both ways
        add_sample(20'hFFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(20'hFFFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        add_sample(20'hFFFFF, 32'h8000_0000, 32'h8000_0000);
        add_sample(20'hFFFFF, 32'h8000_0000, 32'h8000_0000);
        add_sample(20'd1, 32'hFFFF_FFFF, 32'h0000_0001);
        add_sample(20'd1049, 32'h0000_0000, 32'hFFFF_0000);
        add_sample(20'h80000, 32'h5555_5555, 32'hAAAA_AAAA);
        add_sample(20'h7FFFF, 32'hAAAA_AAAA, 32'h5555_5555);
        drain();
        // Register extremes: all noise registers at full scale, then all at zero
        write_reg(CFG_START_ANGLE, 32'h8000_0000);
        write_reg(CFG_Q_ANGLE, 32'hFFFF_FFFF);
        write_reg(CFG_Q_BIAS, 32'hFFFF_FFFF);
        write_reg(CFG_R_ACCEL, 32'hFFFF_FFFF);
        add_sample(20'hFFFFF, 32'h0001_0000, 32'h7FFF_FFFF);
        add_sample(20'hFFFFF, 32'hFFFF_0000, 32'h0000_0000);
        add_sample(20'd1000, 32'h0000_8000, 32'h8000_0000);
        drain();
        write_reg(CFG_START_ANGLE, 32'h7FFF_FFFF);
        write_reg(CFG_Q_ANGLE, 32'd0);
        write_reg(CFG_Q_BIAS, 32'd0);
        write_reg(CFG_R_ACCEL, 32'd0);
        add_sample(20'hFFFFF, 32'h7FFF_FFFF, 32'h8000_0000);
        add_sample(20'd0, 32'h0000_0000, 32'h0000_0000);
        add_sample(20'd1049, 32'h0010_0000, 32'h0020_0000);
        drain();

        // Random phase one: sender idles a little, receiver a lot
        write_reg(CFG_Q_ANGLE, Q_ANGLE_RST);
        write_reg(CFG_Q_BIAS, Q_BIAS_RST);
        write_reg(CFG_R_ACCEL, R_ACCEL_RST);
        tx_idle_pct = 18;
        rx_idle_pct = 87;
        add_random(300);
        drain();
        random_regs();
        add_random(300);
        drain();

        // Random phase two: roles swapped; pause the sender midway until empty
        random_regs();
        tx_idle_pct = 87;
        rx_idle_pct = 18;
        add_random(300);
        drain();
        add_random(300);
        drain();

        // Random phase three: no idling, one long receiver hold-off
        random_regs();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        rx_hold_cnt = RX_HOLD_CYCLES;
        add_random(300);
        drain();
        write_reg(CFG_START_ANGLE, 32'd0);
        write_reg(CFG_Q_ANGLE, Q_ANGLE_RST);
        write_reg(CFG_Q_BIAS, Q_BIAS_RST);
        write_reg(CFG_R_ACCEL, R_ACCEL_RST);
        add_random(330);
        drain();

        if (error_cnt == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== angle_kalman_filter.f =====
rtl/akf_pkg.sv
rtl/akf_mul.sv
rtl/akf_div.sv
rtl/angle_kalman_filter.sv
bench/tb_angle_kalman_filter.sv
